FILE: sv/evm_temporal_iir_bandpass_top_macros.svh
// ----------------------------------------------------------------------------
// evm temporal bandpass assertion macros
// shorthand for clocked assertions on i_clk with active-low i_rst_n
// ----------------------------------------------------------------------------
`ifndef EVM_TEMPORAL_IIR_BANDPASS_TOP_MACROS_SVH
`define EVM_TEMPORAL_IIR_BANDPASS_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define EVM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define EVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after a reset edge
`define EVM_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/evm_pkg.sv
// ----------------------------------------------------------------------------
// evm_pkg
// widths, constants and types shared by the temporal bandpass modules
// ----------------------------------------------------------------------------
package evm_pkg;

    // frame and channel geometry
    localparam int FRAME_PIXELS = 4096;
    localparam int CHANNELS     = 3;
    localparam int LANES        = (CHANNELS < 3) ? CHANNELS : 3;

    // field widths
    localparam int SMP_W   = 16;
    localparam int IDX_W   = 12;
    localparam int LP_W    = 24;
    localparam int COEF_W  = 16;
    localparam int GAIN_W  = 10;
    localparam int BAND_W  = 24;

    // store geometry, the pixel index can address at most 2**IDX_W entries
    localparam int STORE_DEPTH = (FRAME_PIXELS < (1 << IDX_W)) ? FRAME_PIXELS : (1 << IDX_W);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int STORE_W     = LANES * LP_W;

    // stream packing
    localparam int S_FIELDS_W = 3 * SMP_W + IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * BAND_W + IDX_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST = 2'd0,
        CFG_SLOW = 2'd1,
        CFG_GAIN = 2'd2
    } t_cfg_idx;

    localparam logic [COEF_W-1:0] FAST_RESET = 16'd6554;
    localparam logic [COEF_W-1:0] SLOW_RESET = 16'd5461;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd200;

    // per-lane pipeline control from the top level
    typedef struct packed {
        logic s2_load;   // stage 1 item moves into stage 2
        logic out_load;  // stage 2 item moves into the output register
        logic hit;       // stage 1 item reads the value stage 2 just wrote
        logic primed;    // first frame done for the stage 1 item
        logic zero;      // stage 2 item gives a zero band
    } t_lane_ctl;

endpackage

FILE: sv/evm_store.sv
// ----------------------------------------------------------------------------
// evm_store
// one lowpass store: single write port, one registered read port
// ----------------------------------------------------------------------------
module evm_store import evm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [STORE_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [STORE_W-1:0] o_rdata
);

    logic [STORE_W-1:0] r_mem [STORE_DEPTH];
    logic [STORE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while no new item enters
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/evm_lane.sv
// ----------------------------------------------------------------------------
// evm_lane
// one color channel: fast and slow lowpass update, then scaled difference
// ----------------------------------------------------------------------------
module evm_lane import evm_pkg::*; (
    input  logic                     i_clk,
    input  t_lane_ctl                i_ctl,
    input  logic [SMP_W-1:0]         i_sample,
    input  logic [LP_W-1:0]          i_fast_rd,
    input  logic [LP_W-1:0]          i_slow_rd,
    input  logic [COEF_W-1:0]        i_fast_coef,
    input  logic [COEF_W-1:0]        i_slow_coef,
    input  logic [GAIN_W-1:0]        i_gain,
    output logic [LP_W-1:0]          o_fast_wr,
    output logic [LP_W-1:0]          o_slow_wr,
    output logic signed [BAND_W-1:0] o_band
);

    localparam int ACC_W = LP_W + COEF_W + 2;
    localparam int PRD_W = LP_W + GAIN_W;
    localparam int RND_W = PRD_W - 7;
    localparam int BAND_HI = (1 << (BAND_W - 1)) - 1;
    localparam int BAND_LO = (1 << (BAND_W - 1));

    // lp + (x - lp) * f, rounded, which equals lp*(1-f) + x*f
    function automatic logic [LP_W-1:0] f_lowpass(
        input logic [LP_W-1:0]   lp,
        input logic [LP_W-1:0]   x,
        input logic [COEF_W-1:0] f
    );
        logic signed [LP_W:0]    diff;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] acc;
        diff = $signed({1'b0, x}) - $signed({1'b0, lp});
        prod = diff * $signed({1'b0, f});
        acc  = $signed({2'b00, lp, {COEF_W{1'b0}}}) + prod
             + $signed({{(LP_W + 2){1'b0}}, 1'b1, {(COEF_W - 1){1'b0}}});
        return acc[LP_W+COEF_W-1:COEF_W];
    endfunction

    // gain * (fast - slow) / 256, rounded to nearest with ties away from zero, saturated
    function automatic logic [BAND_W-1:0] f_band(
        input logic [LP_W-1:0]   fast,
        input logic [LP_W-1:0]   slow,
        input logic [GAIN_W-1:0] g
    );
        logic signed [LP_W:0] d;
        logic                 neg;
        logic [LP_W-1:0]      mag;
        logic [PRD_W:0]       sum;
        logic [RND_W-1:0]     r;
        logic [BAND_W-1:0]    v;
        d   = $signed({1'b0, fast}) - $signed({1'b0, slow});
        neg = d[LP_W];
        mag = neg ? LP_W'(-d) : LP_W'(d);
        sum = (PRD_W + 1)'(mag) * (PRD_W + 1)'(g) + (PRD_W + 1)'(128);
        r   = sum[PRD_W:8];
        if (neg) begin
            v = (r > RND_W'(BAND_LO)) ? {1'b1, {(BAND_W - 1){1'b0}}} : BAND_W'(-r);
        end else begin
            v = (r > RND_W'(BAND_HI)) ? {1'b0, {(BAND_W - 1){1'b1}}} : BAND_W'(r);
        end
        return v;
    endfunction

    logic [LP_W-1:0]   w_x;
    logic [LP_W-1:0]   w_fast_old;
    logic [LP_W-1:0]   w_slow_old;
    logic [LP_W-1:0]   n_fast;
    logic [LP_W-1:0]   n_slow;
    logic [LP_W-1:0]   r_fast;
    logic [LP_W-1:0]   r_slow;
    logic [BAND_W-1:0] r_band;

    // stage 1: previous values, from the store or forwarded from stage 2
    assign w_x        = {i_sample, 8'h00};
    assign w_fast_old = i_ctl.hit ? r_fast : i_fast_rd;
    assign w_slow_old = i_ctl.hit ? r_slow : i_slow_rd;

    // first frame loads the sample into both filters
    always_comb begin
        if (i_ctl.primed) begin
            n_fast = f_lowpass(w_fast_old, w_x, i_fast_coef);
            n_slow = f_lowpass(w_slow_old, w_x, i_slow_coef);
        end else begin
            n_fast = w_x;
            n_slow = w_x;
        end
    end

    assign o_fast_wr = n_fast;
    assign o_slow_wr = n_slow;

    // stage 2 registers, also the forwarding source
    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_load) begin
            r_fast <= n_fast;
            r_slow <= n_slow;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_band <= i_ctl.zero ? '0 : f_band(r_fast, r_slow, i_gain);
        end
    end

    assign o_band = $signed(r_band);

endmodule

FILE: sv/evm_temporal_iir_bandpass_top.sv
// ----------------------------------------------------------------------------
// evm_temporal_iir_bandpass_top
// per-pixel temporal bandpass for video magnification; with no m side stall, one pixel per clock
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s         in   i_s_tvalid/o_s_tready i_s_tdata: r, g, b, pixel index; tlast: frame end
//  m         out  o_m_tvalid/i_m_tready o_m_tdata: band r, g, b, index; tlast: frame end
//  cfg       in   i_cfg_we              i_cfg_idx, i_cfg_data
//
//  one item per cycle unless m stalls; an item passes stage 1, stage 2 and output register
//  rate is set by the store read-modify-write, closed by forwarding from stage 2
//  stores have no reset and no clearing pass: the first frame must write every pixel,
//  which the block does not check; reset clears the pipeline valids and the primed flag
//  and restores the cfg registers; an m side stall fills the stages, then drops o_s_tready
// ----------------------------------------------------------------------------
module evm_temporal_iir_bandpass_top import evm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // sample_red, sample_green, sample_blue, pixel_index
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // band_red, band_green, band_blue, out_index
    output logic                  o_m_tlast
);

    logic [COEF_W-1:0]  r_fast_coef;
    logic [COEF_W-1:0]  r_slow_coef;
    logic [GAIN_W-1:0]  r_gain;
    logic               r_primed;

    logic               r_s1_valid;
    logic [3*SMP_W-1:0] r_s1_smp;
    logic [IDX_W-1:0]   r_s1_idx;
    logic               r_s1_last;
    logic               r_s1_hit;

    logic               r_s2_valid;
    logic [IDX_W-1:0]   r_s2_idx;
    logic               r_s2_last;
    logic               r_s2_zero;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;

    logic               w_out_take;
    logic               w_s2_adv;
    logic               w_s2_free;
    logic               w_s1_adv;
    logic               w_s1_free;
    logic               w_accept;
    logic               w_s1_in_range;
    logic [IDX_W-1:0]   w_in_idx;
    logic               w_in_hit;

    logic [STORE_W-1:0] w_fast_rd;
    logic [STORE_W-1:0] w_slow_rd;
    logic [STORE_W-1:0] w_fast_wr;
    logic [STORE_W-1:0] w_slow_wr;
    logic [2:0][BAND_W-1:0] w_band;
    t_lane_ctl          w_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_coef <= FAST_RESET;
            r_slow_coef <= SLOW_RESET;
            r_gain      <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FAST: r_fast_coef <= i_cfg_data[COEF_W-1:0];
                CFG_SLOW: r_slow_coef <= i_cfg_data[COEF_W-1:0];
                CFG_GAIN: r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign w_out_take = !r_out_valid || i_m_tready;
    assign w_s2_adv   = r_s2_valid && w_out_take;
    assign w_s2_free  = !r_s2_valid || w_out_take;
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign w_accept   = i_s_tvalid && w_s1_free;
    assign o_s_tready = w_s1_free;

    assign w_in_idx      = i_s_tdata[3*SMP_W +: IDX_W];
    assign w_s1_in_range = (32'(r_s1_idx) < FRAME_PIXELS);
    // the item leaving stage 1 writes the same pixel the new item reads
    assign w_in_hit      = r_s1_valid && w_s1_in_range && (r_s1_idx == w_in_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            // first frame ends with the frame end item
            if (w_s1_adv && !r_primed && r_s1_last) begin
                r_primed <= 1'b1;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_smp  <= i_s_tdata[3*SMP_W-1:0];
            r_s1_idx  <= w_in_idx;
            r_s1_last <= i_s_tlast;
            r_s1_hit  <= w_in_hit;
        end
        if (w_s1_adv) begin
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
            r_s2_zero <= !r_primed || !w_s1_in_range;
        end
        if (w_s2_adv) begin
            r_out_idx  <= r_s2_idx;
            r_out_last <= r_s2_last;
        end
    end

    // lowpass stores
    evm_store u_fast_store (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv && w_s1_in_range),
        .i_waddr (r_s1_idx[ADDR_W-1:0]),
        .i_wdata (w_fast_wr),
        .i_re    (w_accept),
        .i_raddr (w_in_idx[ADDR_W-1:0]),
        .o_rdata (w_fast_rd)
    );

    evm_store u_slow_store (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv && w_s1_in_range),
        .i_waddr (r_s1_idx[ADDR_W-1:0]),
        .i_wdata (w_slow_wr),
        .i_re    (w_accept),
        .i_raddr (w_in_idx[ADDR_W-1:0]),
        .o_rdata (w_slow_rd)
    );

    assign w_ctl.s2_load  = w_s1_adv;
    assign w_ctl.out_load = w_s2_adv;
    assign w_ctl.hit      = r_s1_hit;
    assign w_ctl.primed   = r_primed;
    assign w_ctl.zero     = r_s2_zero;

    // channel lanes; channels without a lane give zero
    for (genvar c = 0; c < 3; c++) begin : g_lane
        if (c < LANES) begin : g_on
            evm_lane u_lane (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_sample    (r_s1_smp[c*SMP_W +: SMP_W]),
                .i_fast_rd   (w_fast_rd[c*LP_W +: LP_W]),
                .i_slow_rd   (w_slow_rd[c*LP_W +: LP_W]),
                .i_fast_coef (r_fast_coef),
                .i_slow_coef (r_slow_coef),
                .i_gain      (r_gain),
                .o_fast_wr   (w_fast_wr[c*LP_W +: LP_W]),
                .o_slow_wr   (w_slow_wr[c*LP_W +: LP_W]),
                .o_band      (w_band[c])
            );
        end else begin : g_off
            assign w_band[c] = '0;
        end
    end

    // merge lanes into the result item
    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, r_out_idx, w_band};

endmodule

FILE: sv/evm_checker.sv
// ----------------------------------------------------------------------------
// evm_checker
// port-level checks on the temporal bandpass top, attached by bind
// ----------------------------------------------------------------------------
`include "evm_temporal_iir_bandpass_top_macros.svh"

module evm_checker import evm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic                 o_m_tlast
);

    logic                r_first;
    logic                w_stall;
    logic [M_TDATA_W:0]  w_item;
    logic [3*BAND_W-1:0] w_bands;

    // result item held back by the receiver
    assign w_stall = o_m_tvalid && !i_m_tready;
    assign w_item  = {o_m_tlast, o_m_tdata};
    assign w_bands = o_m_tdata[3*BAND_W-1:0];

    // result items up to the first frame end belong to the first frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_m_tvalid && i_m_tready && o_m_tlast) begin
            r_first <= 1'b0;
        end
    end

    `EVM_ASSERT_RESET(a_reset_empty, !o_m_tvalid, "result valid right after reset")

    `EVM_ASSERT_NEXT(a_stall_hold, w_stall, o_m_tvalid && $stable(w_item), "stalled item changed")

    `EVM_ASSERT_NOW(a_empty_ready, !o_m_tvalid, o_s_tready, "input stalled with empty output")

    `EVM_ASSERT_NOW(a_first_zero, o_m_tvalid && r_first, w_bands == '0, "band set in first frame")

endmodule

bind evm_temporal_iir_bandpass_top evm_checker u_evm_checker (.*);
